>>> hdl/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int OFF_W      = SIZE_W + IDX_W;
    localparam int SPAN_W     = SIZE_W + CNT_W;
    localparam int DIV_W      = $clog2(IDX_W);

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_NOT_OWNED    = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_READ,
        S_A_ADDR,
        S_F_CHECK,
        S_F_RANGE,
        S_F_DIV,
        S_F_ALIGN,
        S_F_BIT,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] block_address;
        logic [15:0] block_length;
        logic        block_present;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] result_address;
        logic [9:0]  result_index;
        logic [10:0] free_blocks;
    } rsp_word_t;

endpackage

>>> hdl/fixed_block_pool_allocator_unit.sv
// fixed-size block pool allocator
// req channel (req_valid / req_stall / req_word): one allocate or free request per word,
// taken at an edge with req_valid high and req_stall low
// rsp channel (rsp_valid / rsp_stall / rsp_word): one response word per request, unless a
// count write cuts it off; held in an output register until the edge where rsp_stall is low
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes, always ready;
// index 0 base address, 1 block size, 2 block count
// one request is worked on at a time; the free stack and the allocated bits sit in
// two single-port-write memories with registered reads
// allocate: from acceptance to response, a stack read, index times size, and an add
// free: a 10-step restoring divider (one quotient bit a cycle) finds the
// block index, followed by a read of its allocated bit
// the next request is taken in the cycle after the response is loaded, even if the
// receiver still stalls it; a stalled response only holds the next one back
// after reset, and after every write of the block count, a clearing pass over every entry
// refills the free stack and clears the allocated bits; no request is taken meanwhile
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_word_t   rsp_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fsm_t               state_reg, state_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   depth_reg, depth_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [SIZE_W-1:0]  len_reg, len_next;
    logic               present_reg, present_next;
    logic [SPAN_W-1:0]  span_reg, span_next;
    logic [OFF_W-1:0]   rem_reg, rem_next;
    logic [IDX_W-1:0]   q_reg, q_next;
    logic [DIV_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [OFF_W-1:0]   mul_reg, mul_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_word_reg, rsp_word_next;

    logic [IDX_W-1:0]   stack_mem [MAX_BLOCKS];
    logic               alloc_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]   stack_rdata_reg;
    logic               alloc_rdata_reg;

    logic               stack_we;
    logic [IDX_W-1:0]   stack_waddr;
    logic [IDX_W-1:0]   stack_wdata;
    logic [IDX_W-1:0]   stack_raddr;
    logic               alloc_we;
    logic [IDX_W-1:0]   alloc_waddr;
    logic               alloc_wdata;

    logic               req_acc;
    logic               count_wr;
    logic               rsp_load;
    logic [10:0]        cnt_raw;
    logic [CNT_W-1:0]   cnt_eff;
    logic [SIZE_W-1:0]  size_eff;
    logic [ADDR_W:0]    end_addr;
    logic               in_range;
    logic               handle_ok;
    logic [OFF_W-1:0]   trial;
    logic [IDX_W-1:0]   init_val;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    assign req_acc  = req_valid && !req_stall;
    assign count_wr = cfg_valid && (cfg_index == CFG_COUNT);
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign cnt_raw  = cfg_data[10:0];
    assign cnt_eff  = (cnt_raw == 11'd0) ? CNT_W'(1) :
                      (CNT_W'(cnt_raw) > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) :
                      CNT_W'(cnt_raw);
    assign size_eff = (size_reg == '0) ? SIZE_W'(1) : size_reg;

    // pool end without wrap
    assign end_addr  = {1'b0, base_reg} + (ADDR_W + 1)'(span_reg);
    assign in_range  = (addr_reg >= base_reg) && ({1'b0, addr_reg} < end_addr);
    assign handle_ok = present_reg && (len_reg == size_reg);
    assign trial     = OFF_W'(size_eff) << div_cnt_reg;

    // stack image after reinit: count-1 down to 0, index 0 on top
    assign init_val = ({1'b0, clr_reg} < count_reg) ?
                      IDX_W'(count_reg - CNT_W'(1) - CNT_W'(clr_reg)) : '0;

    // top of stack is always read from the current depth
    assign stack_raddr = IDX_W'(depth_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (count_wr)
        begin
            state_next = S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == IDX_W'(MAX_BLOCKS - 1))
                        state_next = S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        if (req_word.req_type == REQ_FREE)
                            state_next = S_F_CHECK;
                        else if (depth_reg == '0)
                            state_next = S_DONE;
                        else
                            state_next = S_A_READ;
                    end
                end
                S_A_READ:  state_next = S_A_ADDR;
                S_A_ADDR:  state_next = S_DONE;
                S_F_CHECK: state_next = handle_ok ? S_F_RANGE : S_DONE;
                S_F_RANGE: state_next = in_range ? S_F_DIV : S_DONE;
                S_F_DIV:
                begin
                    if (div_cnt_reg == '0)
                        state_next = S_F_ALIGN;
                end
                S_F_ALIGN: state_next = (rem_reg != '0) ? S_DONE : S_F_BIT;
                S_F_BIT:   state_next = S_DONE;
                S_DONE:
                begin
                    if (rsp_load)
                        state_next = S_IDLE;
                end
                default:   state_next = S_IDLE;
            endcase
        end
    end

    // datapath and memory controls
    always_comb
    begin
        base_next       = base_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        depth_next      = depth_reg;
        clr_next        = clr_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        present_next    = present_reg;
        span_next       = span_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        div_cnt_next    = div_cnt_reg;
        mul_next        = mul_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_idx_next    = res_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_word_next   = rsp_word_reg;
        stack_we        = 1'b0;
        stack_waddr     = clr_reg;
        stack_wdata     = init_val;
        alloc_we        = 1'b0;
        alloc_waddr     = clr_reg;
        alloc_wdata     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                stack_we = 1'b1;
                alloc_we = 1'b1;
                clr_next = clr_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (req_acc)
                begin
                    addr_next       = req_word.block_address;
                    len_next        = req_word.block_length;
                    present_next    = req_word.block_present;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_idx_next    = '0;
                    if (req_word.req_type == REQ_ALLOC)
                    begin
                        if (depth_reg == '0)
                            res_status_next = ST_EMPTY;
                        else
                            depth_next = depth_reg - CNT_W'(1);
                    end
                end
            end
            S_A_READ:
            begin
                res_idx_next = stack_rdata_reg;
                mul_next     = OFF_W'(stack_rdata_reg * size_eff);
                alloc_we     = 1'b1;
                alloc_waddr  = stack_rdata_reg;
                alloc_wdata  = 1'b1;
            end
            S_A_ADDR:
            begin
                res_addr_next = base_reg + ADDR_W'(mul_reg);
            end
            S_F_CHECK:
            begin
                span_next = SPAN_W'(size_eff * count_reg);
                if (!handle_ok)
                    res_status_next = ST_NOT_OWNED;
            end
            S_F_RANGE:
            begin
                rem_next     = OFF_W'(addr_reg - base_reg);
                q_next       = '0;
                div_cnt_next = DIV_W'(IDX_W - 1);
                if (!in_range)
                    res_status_next = ST_NOT_OWNED;
            end
            S_F_DIV:
            begin
                // one quotient bit a cycle, most significant first
                if (rem_reg >= trial)
                begin
                    rem_next            = rem_reg - trial;
                    q_next[div_cnt_reg] = 1'b1;
                end
                div_cnt_next = div_cnt_reg - DIV_W'(1);
            end
            S_F_ALIGN:
            begin
                if (rem_reg != '0)
                    res_status_next = ST_MISALIGNED;
            end
            S_F_BIT:
            begin
                res_idx_next = q_reg;
                if (!alloc_rdata_reg || (depth_reg >= CNT_W'(MAX_BLOCKS)))
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    alloc_we    = 1'b1;
                    alloc_waddr = q_reg;
                    alloc_wdata = 1'b0;
                    stack_we    = 1'b1;
                    stack_waddr = IDX_W'(depth_reg);
                    stack_wdata = q_reg;
                    depth_next  = depth_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // response register
        if (rsp_load)
        begin
            rsp_valid_next               = 1'b1;
            rsp_word_next.status         = res_status_reg;
            rsp_word_next.result_address = res_addr_reg;
            rsp_word_next.result_index   = 10'(res_idx_reg);
            rsp_word_next.free_blocks    = 11'(depth_reg);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE:  base_next = cfg_data;
                CFG_SIZE:  size_next = cfg_data[SIZE_W-1:0];
                CFG_COUNT:
                begin
                    count_next = cnt_eff;
                    depth_next = cnt_eff;
                    clr_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            base_reg      <= '0;
            size_reg      <= SIZE_W'(64);
            count_reg     <= CNT_W'(MAX_BLOCKS);
            depth_reg     <= CNT_W'(MAX_BLOCKS);
            clr_reg       <= '0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            count_reg     <= count_next;
            depth_reg     <= depth_next;
            clr_reg       <= clr_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        present_reg    <= present_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        mul_reg        <= mul_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_idx_reg    <= res_idx_next;
        rsp_word_reg   <= rsp_word_next;
    end

    // free stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    // allocated bits
    always_ff @(posedge clk)
    begin
        if (alloc_we)
            alloc_mem[alloc_waddr] <= alloc_wdata;
        alloc_rdata_reg <= alloc_mem[q_reg];
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= count_reg)
        else $error("free stack deeper than the block count");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response word raised outside the done state");

    a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_word.req_type == REQ_ALLOC) && (depth_reg == '0) && !count_wr)
        |=> (state_reg == S_DONE) && (res_status_reg == ST_EMPTY))
        else $error("allocate from an empty pool not refused");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_DIV) |-> (div_cnt_reg <= DIV_W'(IDX_W - 1)))
        else $error("divider step count out of range");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_F_BIT) && stack_we) |-> (depth_reg < CNT_W'(MAX_BLOCKS)))
        else $error("push onto a full free stack");
`endif

endmodule

>>> dv/testbench.sv
module testbench;
    import fbpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_word_t   req_word;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_word_t   rsp_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the pool: geometry registers, free stack and ownership bits
    logic [31:0] pool_base;
    logic [15:0] pool_size;
    logic [10:0] pool_count;
    logic [9:0]  spare_idx [MAX_BLOCKS];
    int unsigned spare_top;
    bit          in_use [MAX_BLOCKS];
    int unsigned held_q [$];

    rsp_word_t   pending_rsp_q [$];
    rsp_word_t   want_now;
    int          err_count = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    fixed_block_pool_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint unsigned eff_size();
        return (pool_size == 16'd0) ? 1 : pool_size;
    endfunction

    function automatic longint unsigned eff_count();
        if (pool_count == 11'd0)
            return 1;
        if (pool_count > MAX_BLOCKS)
            return MAX_BLOCKS;
        return pool_count;
    endfunction

    function automatic logic [31:0] slot_addr(int unsigned idx);
        return 32'(pool_base + idx * eff_size());
    endfunction

    function automatic void refill_pool();
        int unsigned n;
        n = eff_count();
        foreach (in_use[i])
            in_use[i] = 1'b0;
        for (int unsigned i = 0; i < n; i++)
            spare_idx[i] = 10'(n - 1 - i);
        spare_top = n;
        held_q.delete();
    endfunction

    // works out the response word for one request and updates the shadow pool
    function automatic rsp_word_t pool_step(req_word_t w);
        rsp_word_t       r;
        longint unsigned sz;
        longint unsigned top_end;
        longint unsigned addr;
        longint unsigned off;
        int unsigned     idx;
        r = '0;
        r.status = ST_OK;
        sz = eff_size();
        addr = w.block_address;
        if (w.req_type == REQ_ALLOC)
        begin
            if (spare_top == 0)
                r.status = ST_EMPTY;
            else
            begin
                spare_top--;
                idx = spare_idx[spare_top];
                in_use[idx] = 1'b1;
                held_q.insert(held_q.size(), idx);
                r.result_index = idx[9:0];
                r.result_address = slot_addr(idx);
            end
        end
        else
        begin
            // pool end is taken without wrap
            top_end = pool_base + sz * eff_count();
            if (!w.block_present || w.block_length != pool_size)
                r.status = ST_NOT_OWNED;
            else if (addr < pool_base || addr >= top_end)
                r.status = ST_NOT_OWNED;
            else
            begin
                off = addr - pool_base;
                if (off % sz != 0)
                    r.status = ST_MISALIGNED;
                else
                begin
                    idx = (off / sz) % MAX_BLOCKS;
                    r.result_index = idx[9:0];
                    if (!in_use[idx] || spare_top >= MAX_BLOCKS)
                        r.status = ST_ALREADY_FREE;
                    else
                    begin
                        in_use[idx] = 1'b0;
                        spare_idx[spare_top] = idx[9:0];
                        spare_top++;
                        for (int k = 0; k < held_q.size(); k++)
                        begin
                            if (held_q[k] == idx)
                            begin
                                held_q.delete(k);
                                break;
                            end
                        end
                    end
                end
            end
        end
        r.free_blocks = 11'(spare_top);
        return r;
    endfunction

    // mostly well-formed traffic: allocations and frees of held blocks
    function automatic req_word_t pick_req();
        req_word_t       w;
        int unsigned     pick;
        int unsigned     idx;
        longint unsigned sz;
        sz = eff_size();
        w.req_type = REQ_FREE;
        w.block_address = $urandom();
        w.block_length = 16'($urandom());
        w.block_present = 1'b1;
        pick = $urandom_range(0, 99);
        if (held_q.size() > 0)
            idx = held_q[$urandom_range(0, held_q.size() - 1)];
        else
            idx = $urandom_range(0, int'(eff_count()) - 1);
        if (pick < 45 || (pick < 75 && held_q.size() == 0))
            w.req_type = REQ_ALLOC;
        else if (pick < 75)
        begin
            w.block_address = slot_addr(idx);
            w.block_length = pool_size;
        end
        else if (pick < 80)
        begin
            // any block in range, often one that is already free
            w.block_address = slot_addr($urandom_range(0, int'(eff_count()) - 1));
            w.block_length = pool_size;
        end
        else if (pick < 85)
        begin
            w.block_address = slot_addr(idx) + $urandom_range(1, (sz > 1) ? int'(sz) - 1 : 1);
            w.block_length = pool_size;
        end
        else if (pick < 89)
        begin
            w.block_address = slot_addr(idx);
            if ($urandom_range(0, 1))
            begin
                w.block_length = pool_size;
                w.block_present = 1'b0;
            end
            else
                w.block_length = pool_size ^ (16'd1 << $urandom_range(0, 15));
        end
        else if (pick < 94)
        begin
            w.block_length = pool_size;
            if ($urandom_range(0, 1))
                w.block_address = 32'(pool_base + sz * eff_count() + $urandom_range(0, 3) * sz);
            else
                w.block_address = pool_base - 32'd1 - $urandom_range(0, 255);
        end
        else
        begin
            w.req_type = 1'($urandom_range(0, 1));
            w.block_present = 1'($urandom_range(0, 1));
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 50)
            $display("%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // one request word; valid stays up into the next call unless a gap follows
    task automatic send_req(req_word_t w);
        int gap;
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (req_stall);
        pending_rsp_q.insert(pending_rsp_q.size(), pool_step(w));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic alloc_one();
        req_word_t w;
        w.req_type = REQ_ALLOC;
        w.block_address = $urandom();
        w.block_length = 16'($urandom());
        w.block_present = 1'($urandom_range(0, 1));
        send_req(w);
    endtask

    task automatic free_at(logic [31:0] addr, logic [15:0] len, logic present);
        req_word_t w;
        w.req_type = REQ_FREE;
        w.block_address = addr;
        w.block_length = len;
        w.block_present = present;
        send_req(w);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // valid is left up when another write follows in the same step
    task automatic write_reg(logic [1:0] idx, logic [31:0] val, bit more = 1'b0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BASE:
                pool_base = val;
            CFG_SIZE:
                pool_size = val[15:0];
            CFG_COUNT:
            begin
                pool_count = val[10:0];
                refill_pool();
            end
            default:
                ;
        endcase
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_pool();
        alloc_one();
        alloc_one();
        alloc_one();
        free_at(32'd64, 16'd64, 1'b1);
        free_at(32'd64, 16'd64, 1'b1);
        alloc_one();
        free_at(32'd64, 16'd64, 1'b0);
        free_at(32'd64, 16'd63, 1'b1);
        free_at(32'd65, 16'd64, 1'b1);
        free_at(32'd65536, 16'd64, 1'b1);
        free_at(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        free_at(32'd0, 16'd64, 1'b1);
    endtask

    task automatic test_exhaust();
        drain();
        write_reg(CFG_COUNT, 32'd2);
        alloc_one();
        alloc_one();
        alloc_one();
        free_at(32'd64, 16'd64, 1'b1);
        free_at(32'd0, 16'd64, 1'b1);
        free_at(32'd0, 16'd64, 1'b1);
        drain();
        // zero count behaves as one block
        write_reg(CFG_COUNT, 32'd0);
        alloc_one();
        alloc_one();
        drain();
        // oversized count saturates to full capacity
        write_reg(CFG_COUNT, 32'd2047);
        alloc_one();
    endtask

    task automatic test_geometry();
        drain();
        write_reg(CFG_BASE, 32'hFFFF_FFF0, 1'b1);
        write_reg(CFG_SIZE, 32'd65535, 1'b1);
        write_reg(CFG_COUNT, 32'd4);
        alloc_one();
        alloc_one();
        // second block wraps past the top of the address space
        free_at(slot_addr(1), 16'd65535, 1'b1);
        free_at(32'hFFFF_FFF0, 16'd65535, 1'b1);
        drain();
        // size change keeps the pool; zero size behaves as one byte
        write_reg(CFG_SIZE, 32'd0);
        free_at(32'hFFFF_FFF1, 16'd0, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [1:0]  reg_q [$];
        logic [31:0] val_q [$];
        int          n;
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            reg_q.delete();
            val_q.delete();
            if ($urandom_range(0, 1))
            begin
                reg_q.insert(reg_q.size(), CFG_BASE);
                case ($urandom_range(0, 3))
                    0: val_q.insert(val_q.size(), 32'd0);
                    1: val_q.insert(val_q.size(), 32'hFFFF_FFFF);
                    2: val_q.insert(val_q.size(), $urandom() & 32'hFFFF_0000);
                    default: val_q.insert(val_q.size(), $urandom());
                endcase
            end
            if ($urandom_range(0, 1))
            begin
                reg_q.insert(reg_q.size(), CFG_SIZE);
                case ($urandom_range(0, 4))
                    0: val_q.insert(val_q.size(), 32'd0);
                    1: val_q.insert(val_q.size(), 32'd1);
                    2: val_q.insert(val_q.size(), 32'd65535);
                    3: val_q.insert(val_q.size(), $urandom_range(1, 16));
                    default: val_q.insert(val_q.size(), $urandom_range(1, 65535));
                endcase
            end
            if ($urandom_range(0, 2) != 0 || reg_q.size() == 0)
            begin
                reg_q.insert(reg_q.size(), CFG_COUNT);
                // small pools mostly, so that they run dry
                case ($urandom_range(0, 9))
                    0: val_q.insert(val_q.size(), 32'd0);
                    1: val_q.insert(val_q.size(), 32'd1);
                    2: val_q.insert(val_q.size(), 32'd1024);
                    3: val_q.insert(val_q.size(), 32'd2047);
                    4: val_q.insert(val_q.size(), $urandom_range(13, 1024));
                    default: val_q.insert(val_q.size(), $urandom_range(1, 12));
                endcase
            end
            foreach (reg_q[k])
                write_reg(reg_q[k], val_q[k], k < reg_q.size() - 1);
            n = $urandom_range(30, 50);
            repeat (n) send_req(pick_req());
        end
    endtask

    // receiver back-pressure in stretches: none, light, heavy, periodic
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                report_mismatch("response word with none expected", rsp_word.result_address, 0);
            else
            begin
                want_now = pending_rsp_q.pop_front();
                if (rsp_word.status !== want_now.status)
                    report_mismatch("status", rsp_word.status, want_now.status);
                if (rsp_word.result_address !== want_now.result_address)
                    report_mismatch("result_address", rsp_word.result_address,
                                    want_now.result_address);
                if (rsp_word.result_index !== want_now.result_index)
                    report_mismatch("result_index", rsp_word.result_index,
                                    want_now.result_index);
                if (rsp_word.free_blocks !== want_now.free_blocks)
                    report_mismatch("free_blocks", rsp_word.free_blocks,
                                    want_now.free_blocks);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = 32'd0;
        pool_base = 32'd0;
        pool_size = 16'd64;
        pool_count = 11'd1024;
        refill_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_pool();
        test_exhaust();
        test_geometry();
        test_random_traffic();
        drain();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> fixed_block_pool_allocator_unit.f
hdl/fbpa_pkg.sv
hdl/fixed_block_pool_allocator_unit.sv
dv/testbench.sv
